FILE: rtl/core/c2s_pkg.sv
// Shared constants and types for the Cartesian to spherical converter.
package c2s_pkg;

  // Output angle format: 2^(ANGLE_WIDTH-1) units per pi
  localparam int ANGLE_WIDTH = 20;

  // CORDIC angle accumulator: 2^31 units per pi, plus headroom
  localparam int ACC_WIDTH = 34;
  localparam int ACC_SHIFT = 12;
  localparam int RND_WIDTH = ACC_WIDTH - ACC_SHIFT;

  typedef logic signed [ACC_WIDTH-1:0] acc_t;
  typedef logic signed [RND_WIDTH-1:0] angle_t;

  localparam acc_t QUARTER_TURN = 34'sd1073741824;
  localparam acc_t ROUND_BIAS   = 34'sd2048;

  // Largest colatitude (pi) in output units
  localparam logic [ANGLE_WIDTH-1:0] HALF_TURN  = 20'd524288;
  localparam angle_t                 HALF_ANGLE = 22'sd524288;

  // atan(2^-i) in accumulator units
  localparam int ATAN_DEPTH = 32;
  localparam logic [30:0] ATAN_LUT [ATAN_DEPTH] = '{
    31'd536870912, 31'd316933406, 31'd167458907, 31'd85004756,
    31'd42667331,  31'd21354465,  31'd10679838,  31'd5340245,
    31'd2670163,   31'd1335087,   31'd667544,    31'd333772,
    31'd166886,    31'd83443,     31'd41721,     31'd20860,
    31'd10430,     31'd5215,      31'd2607,      31'd1303,
    31'd651,       31'd325,       31'd162,       31'd81,
    31'd40,        31'd20,        31'd10,        31'd5,
    31'd2,         31'd1,         31'd0,         31'd0
  };

endpackage

FILE: rtl/core/c2s_square.sv
// Squares of the coordinates and the two sums of squares, three stages.
module c2s_square #(
  parameter int W = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic signed [W-1:0]   x_i,
  input  logic signed [W-1:0]   y_i,
  input  logic signed [W-1:0]   z_i,
  output logic                  valid_o,
  output logic [2*W-1:0]        xy2_o,
  output logic [2*W-1:0]        all2_o,
  output logic [3*W-1:0]        pt_o
);

  logic signed [2*W-1:0] xx, yy, zz;

  logic             vld1_q, vld2_q, vld3_q;
  logic [3*W-1:0]   pt1_q, pt2_q, pt3_q;
  logic [2*W-2:0]   xx_q, yy_q, zz1_q, zz2_q;
  logic [2*W-1:0]   xy2_q, xy2_out_q, all2_q;

  // Square each coordinate; results are never negative
  assign xx = x_i * x_i;
  assign yy = y_i * y_i;
  assign zz = z_i * z_i;

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  // Stage 1 squares, stage 2 planar sum, stage 3 full sum
  always_ff @(posedge clk_i) begin
    pt1_q     <= {x_i, y_i, z_i};
    xx_q      <= xx[2*W-2:0];
    yy_q      <= yy[2*W-2:0];
    zz1_q     <= zz[2*W-2:0];
    pt2_q     <= pt1_q;
    xy2_q     <= {1'b0, xx_q} + {1'b0, yy_q};
    zz2_q     <= zz1_q;
    pt3_q     <= pt2_q;
    xy2_out_q <= xy2_q;
    all2_q    <= xy2_q + {1'b0, zz2_q};
  end

  assign valid_o = vld3_q;
  assign xy2_o   = xy2_out_q;
  assign all2_o  = all2_q;
  assign pt_o    = pt3_q;

endmodule

FILE: rtl/core/c2s_roots.sv
// Two-lane pipelined integer square root, one root bit per stage, rounded to nearest.
module c2s_roots #(
  parameter int W        = 20,
  parameter int SB_WIDTH = 60
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [2*W-1:0]      v_i [2],
  input  logic [SB_WIDTH-1:0] sb_i,
  output logic                valid_o,
  output logic [W-1:0]        root_o [2],
  output logic [SB_WIDTH-1:0] sb_o
);

  localparam int NL = 2;

  logic                vld_q  [W];
  logic [SB_WIDTH-1:0] sb_q   [W];
  logic [2*W-1:0]      opd_q  [NL][W];
  logic [W-1:0]        root_q [NL][W];
  logic [W+1:0]        rem_q  [NL][W];

  logic                vld_out_q;
  logic [SB_WIDTH-1:0] sb_out_q;
  logic [W-1:0]        root_out_q [NL];

  for (genvar j = 0; j < W; j++) begin : g_stage
    logic                vld_in;
    logic [SB_WIDTH-1:0] sb_in;

    if (j == 0) begin : g_first
      assign vld_in = valid_i;
      assign sb_in  = sb_i;
    end else begin : g_next
      assign vld_in = vld_q[j-1];
      assign sb_in  = sb_q[j-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      sb_q[j] <= sb_in;
    end

    for (genvar l = 0; l < NL; l++) begin : g_lane
      logic [2*W-1:0] opd_in;
      logic [W-1:0]   root_in, root_d;
      logic [W+1:0]   rem_in, rem_sh, trial, rem_d;

      if (j == 0) begin : g_first
        assign opd_in  = v_i[l];
        assign root_in = '0;
        assign rem_in  = '0;
      end else begin : g_next
        assign opd_in  = opd_q[l][j-1];
        assign root_in = root_q[l][j-1];
        assign rem_in  = rem_q[l][j-1];
      end

      // Bring down the next two operand bits and try a one root bit
      always_comb begin
        rem_sh = {rem_in[W-1:0], opd_in[2*(W-1-j)+1 -: 2]};
        trial  = {root_in, 2'b01};
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_in[W-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_in[W-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk_i) begin
        opd_q[l][j]  <= opd_in;
        root_q[l][j] <= root_d;
        rem_q[l][j]  <= rem_d;
      end
    end
  end

  // Round up when the remainder exceeds the floor root
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else begin
      vld_out_q <= vld_q[W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    sb_out_q <= sb_q[W-1];
  end

  for (genvar l = 0; l < NL; l++) begin : g_round
    always_ff @(posedge clk_i) begin
      if (rem_q[l][W-1] > {2'b00, root_q[l][W-1]}) begin
        root_out_q[l] <= root_q[l][W-1] + W'(1);
      end else begin
        root_out_q[l] <= root_q[l][W-1];
      end
    end
    assign root_o[l] = root_out_q[l];
  end

  assign valid_o = vld_out_q;
  assign sb_o    = sb_out_q;

  // The final remainder of a correct floor root never exceeds twice the root
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[W-1] |-> (rem_q[0][W-1] <= {1'b0, root_q[0][W-1], 1'b0}) &&
                   (rem_q[1][W-1] <= {1'b0, root_q[1][W-1], 1'b0}))
    else $error("square root remainder out of range");

endmodule

FILE: rtl/core/c2s_cordic.sv
// Two-lane pipelined CORDIC vectoring: quarter-turn prerotation, one iteration per stage.
module c2s_cordic #(
  parameter int W        = 20,
  parameter int STEPS    = 20,
  parameter int SB_WIDTH = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic signed [W:0]     a_i [2],
  input  logic signed [W:0]     b_i [2],
  input  logic [SB_WIDTH-1:0]   sb_i,
  output logic                  valid_o,
  output c2s_pkg::angle_t       angle_o [2],
  output logic [SB_WIDTH-1:0]   sb_o
);

  import c2s_pkg::*;

  localparam int NL = 2;
  localparam int CW = W + 3;

  logic                 pr_vld_q;
  logic [SB_WIDTH-1:0]  pr_sb_q;
  logic signed [CW-1:0] pr_a_q [NL];
  logic signed [CW-1:0] pr_b_q [NL];
  acc_t                 pr_acc_q [NL];
  logic                 pr_zero_q [NL];

  logic                 vld_q  [STEPS];
  logic [SB_WIDTH-1:0]  sb_q   [STEPS];
  logic signed [CW-1:0] a_q    [NL][STEPS];
  logic signed [CW-1:0] b_q    [NL][STEPS];
  acc_t                 acc_q  [NL][STEPS];
  logic                 zero_q [NL][STEPS];

  logic                 vld_out_q;
  logic [SB_WIDTH-1:0]  sb_out_q;
  angle_t               angle_q [NL];

  // Prerotate vectors in the left half plane by a quarter turn
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_vld_q <= 1'b0;
    end else begin
      pr_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pr_sb_q <= sb_i;
  end

  for (genvar l = 0; l < NL; l++) begin : g_pre
    logic signed [CW-1:0] a_ext, b_ext, a_d, b_d;
    acc_t                 acc_d;

    assign a_ext = {{2{a_i[l][W]}}, a_i[l]};
    assign b_ext = {{2{b_i[l][W]}}, b_i[l]};

    always_comb begin
      a_d   = a_ext;
      b_d   = b_ext;
      acc_d = '0;
      if (a_ext[CW-1]) begin
        if (!b_ext[CW-1]) begin
          a_d   = b_ext;
          b_d   = -a_ext;
          acc_d = QUARTER_TURN;
        end else begin
          a_d   = -b_ext;
          b_d   = a_ext;
          acc_d = -QUARTER_TURN;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      pr_a_q[l]    <= a_d;
      pr_b_q[l]    <= b_d;
      pr_acc_q[l]  <= acc_d;
      pr_zero_q[l] <= (a_i[l] == '0) && (b_i[l] == '0);
    end
  end

  // One micro-rotation per stage, driving the second component toward zero
  for (genvar j = 0; j < STEPS; j++) begin : g_step
    localparam acc_t ATAN_J = ACC_WIDTH'(ATAN_LUT[j]);

    logic                vld_in;
    logic [SB_WIDTH-1:0] sb_in;

    if (j == 0) begin : g_first
      assign vld_in = pr_vld_q;
      assign sb_in  = pr_sb_q;
    end else begin : g_next
      assign vld_in = vld_q[j-1];
      assign sb_in  = sb_q[j-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      sb_q[j] <= sb_in;
    end

    for (genvar l = 0; l < NL; l++) begin : g_lane
      logic signed [CW-1:0] a_in, b_in, da, db, a_d, b_d;
      acc_t                 acc_in, acc_d;
      logic                 zero_in;

      if (j == 0) begin : g_first
        assign a_in    = pr_a_q[l];
        assign b_in    = pr_b_q[l];
        assign acc_in  = pr_acc_q[l];
        assign zero_in = pr_zero_q[l];
      end else begin : g_next
        assign a_in    = a_q[l][j-1];
        assign b_in    = b_q[l][j-1];
        assign acc_in  = acc_q[l][j-1];
        assign zero_in = zero_q[l][j-1];
      end

      assign da = b_in >>> j;
      assign db = a_in >>> j;

      // A zero second component counts as positive
      always_comb begin
        if (!b_in[CW-1]) begin
          a_d   = a_in + da;
          b_d   = b_in - db;
          acc_d = acc_in + ATAN_J;
        end else begin
          a_d   = a_in - da;
          b_d   = b_in + db;
          acc_d = acc_in - ATAN_J;
        end
      end

      always_ff @(posedge clk_i) begin
        a_q[l][j]    <= a_d;
        b_q[l][j]    <= b_d;
        acc_q[l][j]  <= acc_d;
        zero_q[l][j] <= zero_in;
      end
    end
  end

  // Round the accumulator to output units; the origin gives zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else begin
      vld_out_q <= vld_q[STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    sb_out_q <= sb_q[STEPS-1];
  end

  for (genvar l = 0; l < NL; l++) begin : g_round
    acc_t acc_rnd;

    assign acc_rnd = acc_q[l][STEPS-1] + ROUND_BIAS;

    always_ff @(posedge clk_i) begin
      if (zero_q[l][STEPS-1]) begin
        angle_q[l] <= '0;
      end else begin
        angle_q[l] <= acc_rnd[ACC_WIDTH-1:ACC_SHIFT];
      end
    end

    assign angle_o[l] = angle_q[l];
  end

  assign valid_o = vld_out_q;
  assign sb_o    = sb_out_q;

  // After prerotation the first component is never negative
  a_pre_right_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pr_vld_q |-> !pr_a_q[0][CW-1] && !pr_a_q[1][CW-1])
    else $error("prerotation left a negative first component");

endmodule

FILE: rtl/core/cartesian_to_spherical.sv
// Top level of the Cartesian to spherical converter.
//
// Converts one point (x, y, z) per request into radius, colatitude and longitude.
// A request is taken whenever start is high; busy stays low, so a new point may
// enter on every clock cycle. Each result appears for one cycle, marked by
// result_valid_o, in request order. The receiver cannot hold a result off, so
// it must take it in that cycle. A request passes through the squaring and
// summing stages, one stage per root bit plus a rounding stage for the two
// square roots, a prerotation stage, one stage per CORDIC iteration and a
// rounding stage for the two angles, and the output register. Angles use 2^19
// units per pi; colatitude is limited to 0..pi and longitude wraps so that pi
// reads as -pi. The origin gives zero angles. There is no internal state to
// reset besides valid bits.
module cartesian_to_spherical #(
  parameter int COORD_WIDTH  = 20,
  parameter int CORDIC_STEPS = 20
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [COORD_WIDTH-1:0]         x_coord_i,
  input  logic signed [COORD_WIDTH-1:0]         y_coord_i,
  input  logic signed [COORD_WIDTH-1:0]         z_coord_i,
  output logic                                  result_valid_o,
  output logic [COORD_WIDTH-1:0]                radius_o,
  output logic [c2s_pkg::ANGLE_WIDTH-1:0]        colatitude_o,
  output logic signed [c2s_pkg::ANGLE_WIDTH-1:0] longitude_o
);

  import c2s_pkg::*;

  localparam int W = COORD_WIDTH;

  logic                 in_vld;
  logic                 sq_vld;
  logic [2*W-1:0]       sq_xy2, sq_all2;
  logic [3*W-1:0]       sq_pt;
  logic [2*W-1:0]       rt_v [2];

  logic                 rt_vld;
  logic [W-1:0]         rt_root [2];
  logic [3*W-1:0]       rt_pt;
  logic signed [W:0]    cd_a [2];
  logic signed [W:0]    cd_b [2];

  logic                 cd_vld;
  angle_t               cd_angle [2];
  logic [W-1:0]         cd_radius;

  logic                   out_vld_q;
  logic [W-1:0]           radius_q;
  logic [ANGLE_WIDTH-1:0] colat_q, colat_d;
  logic [ANGLE_WIDTH-1:0] lon_q;

  // Take a request on every cycle
  assign busy   = 1'b0;
  assign in_vld = start && !busy;

  c2s_square #(
    .W (W)
  ) u_square (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_vld),
    .x_i     (x_coord_i),
    .y_i     (y_coord_i),
    .z_i     (z_coord_i),
    .valid_o (sq_vld),
    .xy2_o   (sq_xy2),
    .all2_o  (sq_all2),
    .pt_o    (sq_pt)
  );

  // Lane 0 gives the radius, lane 1 the distance from the z axis
  assign rt_v[0] = sq_all2;
  assign rt_v[1] = sq_xy2;

  c2s_roots #(
    .W        (W),
    .SB_WIDTH (3*W)
  ) u_roots (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_vld),
    .v_i     (rt_v),
    .sb_i    (sq_pt),
    .valid_o (rt_vld),
    .root_o  (rt_root),
    .sb_o    (rt_pt)
  );

  // Lane 0 measures colatitude from (z, rho), lane 1 longitude from (x, y)
  assign cd_a[0] = {rt_pt[W-1], rt_pt[W-1:0]};
  assign cd_b[0] = {1'b0, rt_root[1]};
  assign cd_a[1] = {rt_pt[3*W-1], rt_pt[3*W-1:2*W]};
  assign cd_b[1] = {rt_pt[2*W-1], rt_pt[2*W-1:W]};

  c2s_cordic #(
    .W        (W),
    .STEPS    (CORDIC_STEPS),
    .SB_WIDTH (W)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rt_vld),
    .a_i     (cd_a),
    .b_i     (cd_b),
    .sb_i    (rt_root[0]),
    .valid_o (cd_vld),
    .angle_o (cd_angle),
    .sb_o    (cd_radius)
  );

  // Limit colatitude to 0..pi
  always_comb begin
    if (cd_angle[0] < 0) begin
      colat_d = '0;
    end else if (cd_angle[0] > HALF_ANGLE) begin
      colat_d = HALF_TURN;
    end else begin
      colat_d = cd_angle[0][ANGLE_WIDTH-1:0];
    end
  end

  // Hold the result for its one strobe cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= cd_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    radius_q <= cd_radius;
    colat_q  <= colat_d;
    lon_q    <= cd_angle[1][ANGLE_WIDTH-1:0];
  end

  assign result_valid_o = out_vld_q;
  assign radius_o       = radius_q;
  assign colatitude_o   = colat_q;
  assign longitude_o    = lon_q;

  a_colat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> colatitude_o <= HALF_TURN)
    else $error("colatitude above pi");

  a_origin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (radius_o == '0) |-> (colatitude_o == '0) && (longitude_o == '0))
    else $error("origin gave a nonzero angle");

endmodule
